FILE: design/esos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esos_pkg
// Shared types and constants for the enclosing sphere block.
// ----------------------------------------------------------------------------
package esos_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadW    = 31;
  localparam int unsigned ExtW    = 33;
  localparam int unsigned SqW     = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned ReachW  = 34;
  localparam logic [ReachW-1:0] RadiusMax = ReachW'(34'h0_7FFF_FFFF);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_DIST,
    ST_SQRT,
    ST_ACC,
    ST_OUT
  } state_t;

endpackage

FILE: design/esos_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esos_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module esos_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [esos_pkg::SqW-1:0]    radicand,
  output logic                        busy,
  output logic [esos_pkg::RootW-1:0]  root
);

  logic [esos_pkg::SqW-1:0]   rem_r, rem_nxt;
  logic [esos_pkg::RootW-1:0] root_r, root_nxt;
  logic [esos_pkg::SqW-1:0]   val_r, val_nxt;
  logic [5:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [esos_pkg::SqW+1:0]   trial;
  logic [esos_pkg::SqW+1:0]   shifted;

  // restoring step: bring down two radicand bits, try 4*root+1
  always_comb begin
    shifted  = {rem_r, val_r[esos_pkg::SqW-1 -: 2]};
    trial    = (esos_pkg::SqW+2)'({root_r, 2'b01});
    rem_nxt  = rem_r;
    root_nxt = root_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      root_nxt = '0;
      val_nxt  = radicand;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[esos_pkg::SqW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = esos_pkg::SqW'(shifted - trial);
        root_nxt = {root_r[esos_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = esos_pkg::SqW'(shifted);
        root_nxt = {root_r[esos_pkg::RootW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    val_r  <= val_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

FILE: design/enclosing_sphere_of_spheres_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enclosing_sphere_of_spheres_top
// Bounding sphere of a set of spheres, centered on the box of sphere extents.
// ----------------------------------------------------------------------------
// Spheres are loaded one per cycle into on-chip memory while the extent box
// grows. After the sphere flagged by tlast the block takes no input: for each
// stored sphere it reads the memory, takes the per-axis distance, squares it
// and launches the bit-serial square root, waits for the root to settle, and
// updates the largest reach; the root is skipped when a center lies 2^31 or
// more from the midpoint on an axis. A closing step registers the result,
// and input stays stalled until the result transfer has taken place.
// A sphere arriving when MAX_SPHERES are stored is dropped and sets the flag.
// ----------------------------------------------------------------------------
module enclosing_sphere_of_spheres_top #(
  parameter int unsigned MAX_SPHERES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], sphere_radius[126:96], zero[127]
  input  logic [127:0]  in_tdata,
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64], enclose_radius[126:96],
  // zero[127]
  output logic [127:0]  out_tdata,
  // saturated
  output logic          out_tuser
);

  localparam int unsigned AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned CW = $clog2(MAX_SPHERES + 1);
  localparam int unsigned EW = esos_pkg::ExtW;

  esos_pkg::state_t state_r, state_nxt;

  // sphere memories
  logic signed [31:0] mem_x [MAX_SPHERES];
  logic signed [31:0] mem_y [MAX_SPHERES];
  logic signed [31:0] mem_z [MAX_SPHERES];
  logic [30:0]        mem_r [MAX_SPHERES];
  logic signed [31:0] rd_x_r, rd_y_r, rd_z_r;
  logic [30:0]        rd_r_r;

  logic signed [EW-1:0] min_x_r, min_y_r, min_z_r, max_x_r, max_y_r, max_z_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 flag_r;
  logic [esos_pkg::ReachW-1:0] best_r;
  logic signed [31:0]   cx_r, cy_r, cz_r;
  logic [EW-1:0]        ax_r, ay_r, az_r;
  logic                 far_r;
  logic [61:0]          sxx_r, syy_r, szz_r;
  logic                 go1_r, go2_r;
  logic [127:0]         out_data_r;
  logic                 out_sat_r;

  logic signed [31:0]   px, py, pz;
  logic [30:0]          pr;
  logic                 accept, store_ok, first;
  logic signed [EW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic signed [EW:0]   sum_x, sum_y, sum_z;
  logic signed [EW-1:0] dx, dy, dz;
  logic [61:0]          mxx, myy, mzz;
  logic [esos_pkg::SqW-1:0] radicand;
  logic                 sq_start, sq_busy;
  logic [esos_pkg::RootW-1:0] root;
  logic [esos_pkg::ReachW-1:0] reach;

  assign px = in_tdata[31:0];
  assign py = in_tdata[63:32];
  assign pz = in_tdata[95:64];
  assign pr = in_tdata[126:96];
  assign in_tready = (state_r == esos_pkg::ST_LOAD);
  assign accept    = in_tvalid && in_tready;
  assign store_ok  = (count_r < CW'(MAX_SPHERES));
  assign first     = (count_r == '0);

  // per-sphere extents
  assign lo_x = EW'(px) - EW'({1'b0, pr});
  assign lo_y = EW'(py) - EW'({1'b0, pr});
  assign lo_z = EW'(pz) - EW'({1'b0, pr});
  assign hi_x = EW'(px) + EW'({1'b0, pr});
  assign hi_y = EW'(py) + EW'({1'b0, pr});
  assign hi_z = EW'(pz) + EW'({1'b0, pr});

  // box midpoint, floor of half the sum
  assign sum_x = (EW+1)'(min_x_r) + (EW+1)'(max_x_r);
  assign sum_y = (EW+1)'(min_y_r) + (EW+1)'(max_y_r);
  assign sum_z = (EW+1)'(min_z_r) + (EW+1)'(max_z_r);

  // per-axis distance to center
  assign dx = EW'(cx_r) - EW'(rd_x_r);
  assign dy = EW'(cy_r) - EW'(rd_y_r);
  assign dz = EW'(cz_r) - EW'(rd_z_r);

  // squares of the in-range distances
  assign mxx = ax_r[30:0] * ax_r[30:0];
  assign myy = ay_r[30:0] * ay_r[30:0];
  assign mzz = az_r[30:0] * az_r[30:0];
  assign radicand = esos_pkg::SqW'(sxx_r) + esos_pkg::SqW'(syy_r)
                  + esos_pkg::SqW'(szz_r);

  assign reach = far_r ? (esos_pkg::RadiusMax + esos_pkg::ReachW'(1))
                       : esos_pkg::ReachW'(root) + esos_pkg::ReachW'(rd_r_r);

  assign sq_start = go2_r && !far_r;

  esos_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .busy     (sq_busy),
    .root     (root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      esos_pkg::ST_LOAD: begin
        idx_nxt = '0;
        if (accept && in_tlast) state_nxt = esos_pkg::ST_READ;
      end
      esos_pkg::ST_READ: begin
        state_nxt = (idx_r == count_r) ? esos_pkg::ST_OUT : esos_pkg::ST_DIST;
      end
      esos_pkg::ST_DIST: state_nxt = esos_pkg::ST_SQRT;
      esos_pkg::ST_SQRT: if (!go1_r && !go2_r && !sq_busy) state_nxt = esos_pkg::ST_ACC;
      esos_pkg::ST_ACC: begin
        idx_nxt   = idx_r + CW'(1);
        state_nxt = esos_pkg::ST_READ;
      end
      esos_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = esos_pkg::ST_LOAD;
          idx_nxt   = '0;
        end
      end
      default: state_nxt = esos_pkg::ST_LOAD;
    endcase
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      mem_x[count_r[AW-1:0]] <= px;
      mem_y[count_r[AW-1:0]] <= py;
      mem_z[count_r[AW-1:0]] <= pz;
      mem_r[count_r[AW-1:0]] <= pr;
    end
    rd_x_r <= mem_x[idx_r[AW-1:0]];
    rd_y_r <= mem_y[idx_r[AW-1:0]];
    rd_z_r <= mem_z[idx_r[AW-1:0]];
    rd_r_r <= mem_r[idx_r[AW-1:0]];
  end

  // center, latched once the box is complete
  always_ff @(posedge clk) begin
    if (state_r == esos_pkg::ST_READ) begin
      cx_r <= 32'(sum_x >>> 1);
      cy_r <= 32'(sum_y >>> 1);
      cz_r <= 32'(sum_z >>> 1);
    end
  end

  // distance pipeline: absolute distances, then squares and far flag
  always_ff @(posedge clk) begin
    ax_r  <= dx[EW-1] ? EW'(-dx) : EW'(dx);
    ay_r  <= dy[EW-1] ? EW'(-dy) : EW'(dy);
    az_r  <= dz[EW-1] ? EW'(-dz) : EW'(dz);
    sxx_r <= mxx;
    syy_r <= myy;
    szz_r <= mzz;
    far_r <= ax_r[EW-1] | ax_r[31] | ay_r[EW-1] | ay_r[31] | az_r[EW-1] | az_r[31];
  end

  // control and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esos_pkg::ST_LOAD;
      count_r <= '0;
      idx_r   <= '0;
      flag_r  <= 1'b0;
      best_r  <= '0;
      go1_r   <= 1'b0;
      go2_r   <= 1'b0;
      min_x_r <= '0; min_y_r <= '0; min_z_r <= '0;
      max_x_r <= '0; max_y_r <= '0; max_z_r <= '0;
      out_sat_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      go1_r   <= (state_r == esos_pkg::ST_DIST);
      go2_r   <= go1_r;
      if (accept) begin
        if (store_ok) begin
          count_r <= count_r + CW'(1);
          if (first || lo_x < min_x_r) min_x_r <= lo_x;
          if (first || lo_y < min_y_r) min_y_r <= lo_y;
          if (first || lo_z < min_z_r) min_z_r <= lo_z;
          if (first || hi_x > max_x_r) max_x_r <= hi_x;
          if (first || hi_y > max_y_r) max_y_r <= hi_y;
          if (first || hi_z > max_z_r) max_z_r <= hi_z;
        end else begin
          flag_r <= 1'b1;
        end
      end
      if (state_r == esos_pkg::ST_ACC && reach > best_r) begin
        best_r <= reach;
      end
      if (state_r == esos_pkg::ST_READ && idx_r == count_r) begin
        out_sat_r <= flag_r || (best_r > esos_pkg::RadiusMax);
      end
      if (state_r == esos_pkg::ST_OUT && out_tready) begin
        count_r <= '0;
        flag_r  <= 1'b0;
        best_r  <= '0;
        min_x_r <= '0; min_y_r <= '0; min_z_r <= '0;
        max_x_r <= '0; max_y_r <= '0; max_z_r <= '0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state_r == esos_pkg::ST_READ && idx_r == count_r) begin
      out_data_r <= {1'b0,
                     (best_r > esos_pkg::RadiusMax) ? 31'h7FFF_FFFF : best_r[30:0],
                     32'(sum_z >>> 1), 32'(sum_y >>> 1), 32'(sum_x >>> 1)};
    end
  end

  assign out_tvalid = (state_r == esos_pkg::ST_OUT);
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != esos_pkg::ST_LOAD) |-> !in_tready) else $error("ready while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SPHERES)) else $error("count overflow");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= count_r) else $error("index past count");
  a_out_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> (count_r == '0 && best_r == '0))
    else $error("set not cleared");
`endif

endmodule

FILE: bench/enclosing_sphere_of_spheres_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enclosing_sphere_of_spheres_top_tb
// Self-checking bench for the enclosing sphere block.
// ----------------------------------------------------------------------------
// Sphere sets are queued up front and fed in random bursts on the input
// stream. A built-in predictor tracks the extent box and the stored spheres
// and works out each set's center, radius and clamp flag. The monitor checks
// every output transfer against the oldest prediction. The receiver stalls
// at random and holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module enclosing_sphere_of_spheres_top_tb;

  localparam int unsigned MaxSpheres = 256;
  localparam int unsigned IdleLimit  = 60000;
  localparam int unsigned LongHold   = 3000;

  typedef struct packed {
    logic [esos_pkg::CoordW-1:0] x;
    logic [esos_pkg::CoordW-1:0] y;
    logic [esos_pkg::CoordW-1:0] z;
    logic [esos_pkg::RadW-1:0]   r;
    logic                        last;
  } sphere_t;

  typedef struct packed {
    logic [esos_pkg::CoordW-1:0] cx;
    logic [esos_pkg::CoordW-1:0] cy;
    logic [esos_pkg::CoordW-1:0] cz;
    logic [esos_pkg::RadW-1:0]   rad;
    logic                        sat;
  } bound_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tuser;

  enclosing_sphere_of_spheres_top #(.MAX_SPHERES(MaxSpheres)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  sphere_t sphere_q[$];
  bound_t  bound_q[$];
  int      errors = 0;
  int      items_sent = 0;
  int      bounds_seen = 0;
  int      sets_queued = 0;
  int      idle_cycles = 0;
  bit      took_in = 1'b0;

  // predictor state
  longint  sx[MaxSpheres];
  longint  sy[MaxSpheres];
  longint  sz[MaxSpheres];
  longint  sr[MaxSpheres];
  longint  mn_x = 0, mn_y = 0, mn_z = 0, mx_x = 0, mx_y = 0, mx_z = 0;
  int      n_stored = 0;
  bit      drop_flag = 1'b0;

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt  = 64'h1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint abs_dist(longint a, longint b);
    longint d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  // fold one accepted sphere into the set, predict the bound on the last one
  task automatic bound_update(sphere_t s);
    longint px, py, pz, rr, cx, cy, cz, dx, dy, dz;
    logic [63:0] reach, best;
    bound_t b;
    px = longint'(signed'(s.x));
    py = longint'(signed'(s.y));
    pz = longint'(signed'(s.z));
    rr = longint'(s.r);
    if (n_stored < MaxSpheres) begin
      if (n_stored == 0 || px - rr < mn_x) mn_x = px - rr;
      if (n_stored == 0 || px + rr > mx_x) mx_x = px + rr;
      if (n_stored == 0 || py - rr < mn_y) mn_y = py - rr;
      if (n_stored == 0 || py + rr > mx_y) mx_y = py + rr;
      if (n_stored == 0 || pz - rr < mn_z) mn_z = pz - rr;
      if (n_stored == 0 || pz + rr > mx_z) mx_z = pz + rr;
      sx[n_stored] = px;
      sy[n_stored] = py;
      sz[n_stored] = pz;
      sr[n_stored] = rr;
      n_stored++;
    end else begin
      drop_flag = 1'b1;
    end
    if (s.last) begin
      cx = (mn_x + mx_x) >>> 1;
      cy = (mn_y + mx_y) >>> 1;
      cz = (mn_z + mx_z) >>> 1;
      best = 0;
      for (int i = 0; i < n_stored; i++) begin
        dx = abs_dist(cx, sx[i]);
        dy = abs_dist(cy, sy[i]);
        dz = abs_dist(cz, sz[i]);
        if (dx >= 64'h8000_0000 || dy >= 64'h8000_0000 || dz >= 64'h8000_0000) begin
          reach = 64'h8000_0000;
        end else begin
          reach = sqrt_floor(64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz)) + 64'(sr[i]);
        end
        if (reach > best) best = reach;
      end
      b.cx  = cx[31:0];
      b.cy  = cy[31:0];
      b.cz  = cz[31:0];
      b.sat = drop_flag;
      if (best > 64'h7FFF_FFFF) begin
        best  = 64'h7FFF_FFFF;
        b.sat = 1'b1;
      end
      b.rad = best[30:0];
      bound_q.push_back(b);
      n_stored  = 0;
      drop_flag = 1'b0;
      mn_x = 0; mn_y = 0; mn_z = 0; mx_x = 0; mx_y = 0; mx_z = 0;
    end
  endtask

  task automatic push_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [30:0] r, logic last);
    sphere_t s;
    s.x = x; s.y = y; s.z = z; s.r = r; s.last = last;
    sphere_q.push_back(s);
    if (last) sets_queued++;
  endtask

  // a set of n spheres; wide sets use the full range, others cluster near a base
  task automatic push_set(int n, bit wide);
    logic [31:0] bx, by, bz;
    bx = $urandom;
    by = $urandom;
    bz = $urandom;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        push_sphere($urandom, $urandom, $urandom, 31'($urandom), i == n - 1);
      end else begin
        push_sphere(bx + $urandom_range(0, 32'h000F_FFFF),
                    by + $urandom_range(0, 32'h000F_FFFF),
                    bz + $urandom_range(0, 32'h000F_FFFF),
                    31'($urandom_range(0, 32'h0003_FFFF)), i == n - 1);
      end
    end
  endtask

  // fill the item queue
  initial begin
    int n;
    // lone spheres at the field extremes
    push_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 1'b1);
    push_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    push_sphere(32'h0, 32'h0, 32'h0, 31'h0, 1'b1);
    push_sphere(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 31'h2AAA_AAAA, 1'b1);
    // far center: opposite corners of the coordinate range
    push_sphere(32'h8000_0000, 32'h0, 32'h0, 31'h0, 1'b0);
    push_sphere(32'h7FFF_FFFF, 32'h0, 32'h0, 31'h0, 1'b1);
    // large reach: distance plus big radius nears the limit without crossing it
    push_sphere(32'h4000_0000, 32'h0, 32'h0, 31'h0, 1'b0);
    push_sphere(32'hC000_0000, 32'h0, 32'h0, 31'h7000_0000, 1'b1);
    // small coordinates on both sides of zero
    push_sphere(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0003, 31'h0, 1'b0);
    push_sphere(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 31'h1, 1'b1);
    // a nested sphere that dominates the radius
    push_sphere(32'h0001_0000, 32'h0, 32'h0, 31'h0000_1000, 1'b0);
    push_sphere(32'h0, 32'h0, 32'h0, 31'h0010_0000, 1'b0);
    push_sphere(32'hFFFF_0000, 32'h0, 32'h0, 31'h0, 1'b1);
    // random sets, mostly small
    while (sphere_q.size() < 135) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      push_set(n, $urandom_range(0, 3) == 0);
    end
    // exactly full store, then full store with dropped spheres
    push_set(MaxSpheres, 1'b0);
    push_set(MaxSpheres + 3, 1'b0);
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // input driver: bursts with random gaps, inputs move on the falling edge
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    sphere_t s;
    if (rst_n && (!in_tvalid || took_in)) begin
      if (gap_left > 0 || sphere_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        s = sphere_q.pop_front();
        in_tdata  <= {1'b0, s.r, s.z, s.y, s.x};
        in_tlast  <= s.last;
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: random stalls, free-running stretches, one long hold-off
  int  ready_mode = 0;
  int  mode_left  = 0;
  int  hold_left  = 0;
  bit  held_once  = 1'b0;

  always @(negedge clk) begin
    if (!held_once && bounds_seen == 6) begin
      held_once = 1'b1;
      hold_left = LongHold;
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(5, 60);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (ready_mode == 0) begin
      out_tready <= 1'b1;
    end else if (ready_mode == 1) begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor: sample both transfers on the rising edge
  always @(posedge clk) begin
    bound_t want;
    bound_t got;
    bit     moved;
    if (rst_n) begin
      moved   = 1'b0;
      took_in = 1'b0;
      if (in_tvalid && in_tready) begin
        bound_update({in_tdata[31:0], in_tdata[63:32], in_tdata[95:64],
                      in_tdata[126:96], in_tlast});
        items_sent++;
        took_in = 1'b1;
        moved   = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        bounds_seen++;
        got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
               out_tdata[126:96], out_tuser};
        if (bound_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = bound_q.pop_front();
          if (got.cx !== want.cx) begin
            $display("%0t: center_x expected %h actual %h", $time, want.cx, got.cx);
            errors++;
          end
          if (got.cy !== want.cy) begin
            $display("%0t: center_y expected %h actual %h", $time, want.cy, got.cy);
            errors++;
          end
          if (got.cz !== want.cz) begin
            $display("%0t: center_z expected %h actual %h", $time, want.cz, got.cz);
            errors++;
          end
          if (got.rad !== want.rad) begin
            $display("%0t: enclose_radius expected %h actual %h", $time, want.rad,
                     got.rad);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
            errors++;
          end
        end
      end
      // watchdog on cycles with no transfer at all
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("** enclosing_sphere_of_spheres_top: FAILED **");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    @(posedge rst_n);
    wait (sphere_q.size() == 0 && !in_tvalid && bounds_seen == sets_queued);
    repeat (200) @(posedge clk);
    $display("covered %0d spheres in %0d sets, extremes, far centers and full store",
             items_sent, bounds_seen);
    if (errors == 0 && bound_q.size() == 0) begin
      $display("** enclosing_sphere_of_spheres_top: PASSED **");
    end else begin
      if (bound_q.size() != 0) $display("%0d results never arrived", bound_q.size());
      $display("** enclosing_sphere_of_spheres_top: FAILED **");
    end
    $finish;
  end

endmodule
